### src/ats_pkg.sv
// Shared types, constants and codes for the ancestor threshold search core.
package ats_pkg;

    // Field widths
    localparam int ACT_W   = 2;
    localparam int ID_W    = 17;
    localparam int VAL_W   = 31;
    localparam int DEPTH_W = 17;

    // Tree capacity and lifting depth
    localparam int MAX_NODES   = 131072;
    localparam int LIFT_LEVELS = 17;
    localparam int NODE_AW     = $clog2(MAX_NODES);
    localparam int LVL_W       = $clog2(LIFT_LEVELS);

    // Depth saturates at the smaller of the lifting span and the field maximum
    localparam longint LIFT_SPAN = (64'd1 << LIFT_LEVELS) - 64'd1;
    localparam longint DEPTH_FIELD_MAX = (64'd1 << DEPTH_W) - 64'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_CAP =
        (LIFT_SPAN < DEPTH_FIELD_MAX) ? DEPTH_W'(LIFT_SPAN) : {DEPTH_W{1'b1}};

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [ID_W-1:0]    node_id;
        logic [ID_W-1:0]    parent_id;
        logic [VAL_W-1:0]   amount;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [ID_W-1:0]    ancestor_id;
    } out_item_t;

    // One stored node: value, depth and its whole jump row
    typedef struct packed {
        logic [VAL_W-1:0]                   value;
        logic [DEPTH_W-1:0]                 depth;
        logic [LIFT_LEVELS-1:0][ID_W-1:0]   jump;
    } row_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_EV,
        ST_ADD_WR,
        ST_Q_START,
        ST_Q_INIT,
        ST_Q_MID,
        ST_Q_RD,
        ST_Q_EV,
        ST_Q_OUT
    } state_t;

    typedef enum logic [1:0] {
        RD_PREV,
        RD_NODE,
        RD_CUR
    } rd_src_t;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        rd_src_t    rd_src;
        logic       add_step;
        logic       add_write;
        logic       q_init;
        logic       q_mid;
        logic       q_step;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       add_ok;
        logic       query_ok;
        logic       add_last;
        logic       loop_go;
        logic       lift_live;
        logic       lift_jump;
    } dp_status_t;

endpackage

### src/ats_datapath.sv
// Datapath: node table memory, add row builder, search and lifting registers.
module ats_datapath import ats_pkg::*;
(
    input  logic        clk,
    input  in_item_t    in_data,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    output out_item_t   out_data
);

    // Root is never written: it always reads as value 1, depth 0, jumps to itself
    localparam row_t ROOT_ROW = '{value: VAL_W'(1), depth: '0, jump: '0};

    function automatic logic id_in_range(input logic [ID_W-1:0] id);
        return longint'(id) < longint'(MAX_NODES);
    endfunction

    // Highest set bit of a depth, capped at the top lifting level
    function automatic logic [LVL_W-1:0] top_level(input logic [DEPTH_W-1:0] d);
        logic [LVL_W-1:0] t;
        t = '0;
        for (int i = 0; i < DEPTH_W; i++) begin
            if (d[i])
            begin
                t = (i < LIFT_LEVELS) ? LVL_W'(i) : LVL_W'(LIFT_LEVELS - 1);
            end
        end
        return t;
    endfunction

    row_t                               mem [MAX_NODES];
    row_t                               rd_row_reg;
    logic                               rd_root_reg;
    row_t                               row;
    logic [ID_W-1:0]                    rd_id;

    in_item_t                           in_reg;
    logic [ID_W-1:0]                    prev_reg;
    logic [LVL_W-1:0]                   k_reg;
    logic [LIFT_LEVELS-1:0][ID_W-1:0]   build_reg;
    logic [DEPTH_W-1:0]                 depth_new_reg;

    logic [DEPTH_W:0]                   lo_reg;
    logic [DEPTH_W-1:0]                 hi_reg;
    logic [DEPTH_W-1:0]                 mid_reg;
    logic [ID_W-1:0]                    cur_reg;
    logic [LVL_W-1:0]                   lvl_reg;
    logic                               live_reg;
    logic [LVL_W-1:0]                   top_reg;
    logic                               topv_reg;
    logic                               found_reg;
    logic [ID_W-1:0]                    best_reg;
    out_item_t                          out_reg;

    logic [LVL_W-1:0]                   kk;
    logic [ID_W-1:0]                    jump_src;
    logic [DEPTH_W:0]                   mid_sum;
    logic [DEPTH_W:0]                   lift_goal;
    logic                               hit;
    row_t                               new_row;

    // Select the node whose row is read
    always_comb
    begin
        case (cmd.rd_src)
            RD_PREV: rd_id = prev_reg;
            RD_NODE: rd_id = in_reg.node_id;
            RD_CUR:  rd_id = cur_reg;
            default: rd_id = cur_reg;
        endcase
    end

    // Node table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.add_write)
        begin
            mem[NODE_AW'(in_reg.node_id)] <= new_row;
        end
        if (cmd.rd_en)
        begin
            rd_row_reg  <= mem[NODE_AW'(rd_id)];
            rd_root_reg <= (rd_id == '0);
        end
    end

    assign row = rd_root_reg ? ROOT_ROW : rd_row_reg;

    // Add: a row just being built is read from the builder, not the memory
    assign kk       = k_reg - LVL_W'(1);
    assign jump_src = (prev_reg == in_reg.node_id) ? build_reg[kk] : row.jump[kk];

    assign new_row.value = in_reg.amount;
    assign new_row.depth = depth_new_reg;
    assign new_row.jump  = build_reg;

    // Search arithmetic
    assign mid_sum   = lo_reg + {1'b0, hi_reg};
    assign lift_goal = {1'b0, mid_reg} + ((DEPTH_W + 1)'(1) << lvl_reg);
    assign hit       = (row.value >= in_reg.amount);

    always_ff @(posedge clk)
    begin
        // Capture the transaction and seed the add chain
        if (cmd.capture)
        begin
            in_reg       <= in_data;
            prev_reg     <= in_data.parent_id;
            k_reg        <= LVL_W'(1);
            build_reg[0] <= in_data.parent_id;
            found_reg    <= 1'b0;
            best_reg     <= '0;
        end

        // Advance one level of the jump row
        if (cmd.add_step)
        begin
            build_reg[k_reg] <= jump_src;
            prev_reg         <= jump_src;
            k_reg            <= k_reg + LVL_W'(1);
            if (k_reg == LVL_W'(1))
            begin
                depth_new_reg <= (row.depth >= DEPTH_CAP) ? DEPTH_CAP
                                                         : row.depth + DEPTH_W'(1);
            end
        end

        // Open the search range over the queried node's depth
        if (cmd.q_init)
        begin
            lo_reg   <= '0;
            hi_reg   <= row.depth;
            top_reg  <= top_level(row.depth);
            topv_reg <= (row.depth != '0);
        end

        // Start a lift toward the middle depth
        if (cmd.q_mid)
        begin
            mid_reg  <= mid_sum[DEPTH_W:1];
            cur_reg  <= in_reg.node_id;
            lvl_reg  <= top_reg;
            live_reg <= topv_reg;
        end

        // Lift one level, or judge the reached ancestor
        if (cmd.q_step)
        begin
            if (live_reg)
            begin
                if (status.lift_jump)
                begin
                    cur_reg <= row.jump[lvl_reg];
                end
                if (lvl_reg == '0)
                begin
                    live_reg <= 1'b0;
                end
                else
                begin
                    lvl_reg <= lvl_reg - LVL_W'(1);
                end
            end
            else if (hit)
            begin
                found_reg <= 1'b1;
                best_reg  <= cur_reg;
                // Hit at depth zero ends the search
                if (mid_reg == '0)
                begin
                    lo_reg <= (DEPTH_W + 1)'(1);
                    hi_reg <= '0;
                end
                else
                begin
                    hi_reg <= mid_reg - DEPTH_W'(1);
                end
            end
            else
            begin
                lo_reg <= {1'b0, mid_reg} + (DEPTH_W + 1)'(1);
            end
        end

        // Load the result register
        if (cmd.out_load)
        begin
            out_reg.found       <= found_reg;
            out_reg.ancestor_id <= best_reg;
        end
    end

    assign status.add_ok    = (in_data.node_id != '0) && id_in_range(in_data.node_id)
                              && id_in_range(in_data.parent_id);
    assign status.query_ok  = id_in_range(in_data.node_id);
    assign status.add_last  = (k_reg >= LVL_W'(LIFT_LEVELS - 1));
    assign status.loop_go   = (lo_reg <= {1'b0, hi_reg});
    assign status.lift_live = live_reg;
    assign status.lift_jump = ({1'b0, row.depth} >= lift_goal);

    assign out_data = out_reg;

endmodule

### src/ats_ctrl.sv
// Controller: sequences add, query and result hand-off over the datapath.
module ats_ctrl import ats_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  action_t     in_action,
    output logic        out_valid,
    input  logic        out_ready,
    input  dp_status_t  status,
    output ctrl_cmd_t   cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Hold state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_src = RD_CUR;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (in_action)
                        ACT_ADD:
                        begin
                            if (status.add_ok)
                            begin
                                state_next = ST_ADD_RD;
                            end
                        end
                        ACT_QUERY:
                        begin
                            state_next = status.query_ok ? ST_Q_START : ST_Q_OUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_PREV;
                state_next = ST_ADD_EV;
            end
            ST_ADD_EV:
            begin
                cmd.add_step = 1'b1;
                state_next   = status.add_last ? ST_ADD_WR : ST_ADD_RD;
            end
            ST_ADD_WR:
            begin
                cmd.add_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_Q_START:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_NODE;
                state_next = ST_Q_INIT;
            end
            ST_Q_INIT:
            begin
                cmd.q_init = 1'b1;
                state_next = ST_Q_MID;
            end
            ST_Q_MID:
            begin
                if (status.loop_go)
                begin
                    cmd.q_mid  = 1'b1;
                    state_next = ST_Q_RD;
                end
                else
                begin
                    state_next = ST_Q_OUT;
                end
            end
            ST_Q_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_CUR;
                state_next = ST_Q_EV;
            end
            ST_Q_EV:
            begin
                cmd.q_step = 1'b1;
                if (status.lift_live)
                begin
                    state_next = status.lift_jump ? ST_Q_RD : ST_Q_EV;
                end
                else
                begin
                    state_next = ST_Q_MID;
                end
            end
            ST_Q_OUT:
            begin
                // Wait for the result register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Set result valid on load, drop it once taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### src/ancestor_threshold_search_core.sv
// Top level of the ancestor threshold search core.
//
// Holds a rooted tree (value, depth and binary-lifting jump row per node) and
// answers threshold queries over a node's ancestor chain.
// Input channel in_valid/in_ready/in_data: action 0 is a clear that writes no row of
// the table, 1 adds node_id under parent_id with value amount, 2 queries node_id
// against the threshold amount, 3 is dropped. Only a query yields a result transaction on
// out_valid/out_ready/out_data: found and the shallowest qualifying ancestor.
// One transaction is processed at a time; in_ready is high only when idle.
// Clear and dropped actions return the block straight to idle. An add makes one
// dependent jump-row read per lifting level above the first, through the single
// read port of the node table. A query first reads the queried node's row, then
// runs about log2(depth)+1 search steps; each step reads its start row and lifts
// one level at a time from the depth's top bit down, reading a new row for each
// jump taken, before it judges the reached ancestor.
// The root row is fixed in logic, so reset and clear need no sweep of the
// table: the block is ready in the first cycle after reset.
// A finished result waits in an output register; while the receiver stalls,
// the next transaction is accepted and worked on up to its own result.
module ancestor_threshold_search_core import ats_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ats_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_action (in_data.action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ats_datapath u_datapath (
        .clk      (clk),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

### src/ats_checker.sv
// Port-level assertions for the ancestor threshold search core, with bind.
module ats_checker import ats_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_data
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A miss reports ancestor zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.ancestor_id == '0)
        else $error("miss with nonzero ancestor");

    // A query always keeps the block busy in the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action == ACT_QUERY |=> !in_ready)
        else $error("ready right after a query");

    // Clear, add and dropped actions produce no result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action != ACT_QUERY && !out_valid
        |=> !out_valid)
        else $error("result without a query");

endmodule

bind ancestor_threshold_search_core ats_checker u_checker (.*);

### verif/ancestor_threshold_search_core_tb.sv
// Testbench for the ancestor threshold search core: directed table, then random tree traffic.
module ancestor_threshold_search_core_tb;
    import ats_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_TOP       = (1 << ID_W) - 1;
    localparam int VAL_TOP      = 32'h7FFF_FFFF;
    localparam int RANDOM_ITEMS = 785;
    localparam int CALM_FIRST   = 400;
    localparam int CALM_LAST    = 520;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 1000;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t answer;
    } directed_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    // Tree as the block should hold it; missing keys read as zero
    logic [VAL_W-1:0] tree_value [int];
    int               tree_depth [int];
    int               tree_jump  [int];

    // Nodes that may be named as parent or queried since the last clear
    int tree_nodes [$];
    bit tree_member [int];
    int last_added;

    out_item_t     pending_answers [$];
    out_item_t     want;
    directed_row_t directed_rows [$];
    int            mismatch_count = 0;
    int            stalled_cycles = 0;
    bit            calm = 1'b0;

    ancestor_threshold_search_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int depth_of(int node);
        return tree_depth.exists(node) ? tree_depth[node] : 0;
    endfunction

    function automatic logic [VAL_W-1:0] value_of(int node);
        return tree_value.exists(node) ? tree_value[node] : '0;
    endfunction

    function automatic int jump_at(int node, int lvl);
        int key;
        if (node >= MAX_NODES || lvl >= LIFT_LEVELS)
            return 0;
        key = node * LIFT_LEVELS + lvl;
        return tree_jump.exists(key) ? tree_jump[key] : 0;
    endfunction

    function automatic void reset_tree();
        tree_value.delete();
        tree_depth.delete();
        tree_jump.delete();
        tree_value[0] = VAL_W'(1);
    endfunction

    // Update the tree for one transaction; return 1 when a search answer is due
    function automatic bit apply_to_tree(input in_item_t item, output out_item_t answer);
        int node;
        int parent;
        int d;
        int prev;
        int lo;
        int hi;
        int mid;
        int anc;
        int top;
        int best;
        int i;
        bit hit;
        node   = int'(item.node_id);
        parent = int'(item.parent_id);
        answer = '0;
        case (item.action)
            ACT_CLEAR:
            begin
                reset_tree();
                return 1'b0;
            end
            ACT_ADD:
            begin
                if (node == 0 || node >= MAX_NODES || parent >= MAX_NODES)
                    return 1'b0;
                d = depth_of(parent);
                d = (d >= int'(DEPTH_CAP)) ? int'(DEPTH_CAP) : d + 1;
                tree_value[node] = item.amount;
                tree_depth[node] = d;
                // Build the row in place, so a loop back to the node sees new entries
                tree_jump[node * LIFT_LEVELS] = parent;
                prev = parent;
                for (i = 1; i < LIFT_LEVELS; i++)
                begin
                    prev = jump_at(prev, i - 1);
                    tree_jump[node * LIFT_LEVELS + i] = prev;
                end
                return 1'b0;
            end
            ACT_QUERY:
            begin
                hit  = 1'b0;
                best = 0;
                if (node < MAX_NODES)
                begin
                    lo  = 0;
                    hi  = depth_of(node);
                    top = -1;
                    while (top + 1 < LIFT_LEVELS && (1 << (top + 1)) <= depth_of(node))
                        top++;
                    // Binary search over target depths, lifting down to each one
                    while (lo <= hi)
                    begin
                        mid = (lo + hi) / 2;
                        anc = node;
                        for (i = top; i >= 0; i--)
                            if (depth_of(anc) - (1 << i) >= mid)
                                anc = jump_at(anc, i);
                        if (value_of(anc) >= item.amount)
                        begin
                            hit  = 1'b1;
                            best = anc;
                            hi   = mid - 1;
                        end
                        else
                            lo = mid + 1;
                    end
                end
                answer.found       = hit;
                answer.ancestor_id = hit ? ID_W'(best) : '0;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic directed_row_t step_row(action_t act, int node, int parent, int amount,
                                               bit typed = 1'b0, bit found = 1'b0,
                                               int anc = 0);
        directed_row_t r;
        r.item.action        = act;
        r.item.node_id       = ID_W'(node);
        r.item.parent_id     = ID_W'(parent);
        r.item.amount        = VAL_W'(amount);
        r.typed              = typed;
        r.answer.found       = found;
        r.answer.ancestor_id = ID_W'(anc);
        return r;
    endfunction

    // Offer one transaction, wait for acceptance, then log what it should produce
    task automatic send_transaction(input in_item_t item, input bit typed,
                                    input out_item_t answer);
        out_item_t predicted;
        int        node;
        if (!calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (apply_to_tree(item, predicted))
            pending_answers = {pending_answers, (typed ? answer : predicted)};
        // Track which nodes stimulus may legally reference
        node = int'(item.node_id);
        if (item.action == ACT_CLEAR)
        begin
            tree_nodes.delete();
            tree_member.delete();
            tree_nodes = {tree_nodes, 0};
            tree_member[0] = 1'b1;
            last_added = 0;
        end
        else if (item.action == ACT_ADD && node != 0)
        begin
            if (!tree_member.exists(node))
            begin
                tree_member[node] = 1'b1;
                tree_nodes = {tree_nodes, node};
            end
            last_added = node;
        end
    endtask

    // Check result transactions and drive the receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result transaction: found=%0d ancestor_id=%0d",
                       out_data.found, out_data.ancestor_id);
                mismatch_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (out_data.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, out_data.found);
                    mismatch_count++;
                end
                if (out_data.ancestor_id !== want.ancestor_id)
                begin
                    $error("ancestor_id: expected %0d, got %0d",
                           want.ancestor_id, out_data.ancestor_id);
                    mismatch_count++;
                end
            end
        end
        out_ready <= calm || ($urandom_range(99) >= 20);
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled_cycles <= 0;
            else
                stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        in_item_t item;
        int       counted;
        int       roll;
        int       pick;
        int       qnode;
        int       i;

        in_valid  <= 1'b0;
        in_data   <= '0;
        rst_n     <= 1'b0;
        reset_tree();
        tree_nodes = {tree_nodes, 0};
        tree_member[0] = 1'b1;
        last_added = 0;

        directed_rows = '{
            // bare root after reset holds value one
            step_row(ACT_QUERY, 0, 0, 0, 1'b1, 1'b1, 0),
            step_row(ACT_QUERY, 0, 0, 1, 1'b1, 1'b1, 0),
            step_row(ACT_QUERY, 0, 0, 2, 1'b1, 1'b0, 0),
            step_row(ACT_QUERY, 0, 0, VAL_TOP, 1'b1, 1'b0, 0),
            // an add aimed at the root is dropped
            step_row(ACT_ADD, 0, 77, VAL_TOP),
            step_row(ACT_QUERY, 0, 0, 2, 1'b1, 1'b0, 0),
            // chain root, 1, top id, 2 with extreme values
            step_row(ACT_ADD, 1, 0, VAL_TOP),
            step_row(ACT_QUERY, 1, 0, VAL_TOP, 1'b1, 1'b1, 1),
            step_row(ACT_QUERY, 1, 0, 1, 1'b1, 1'b1, 0),
            step_row(ACT_ADD, ID_TOP, 1, 0),
            step_row(ACT_QUERY, ID_TOP, 0, 0, 1'b1, 1'b1, 0),
            step_row(ACT_QUERY, ID_TOP, 0, 2, 1'b1, 1'b1, 1),
            step_row(ACT_ADD, 2, ID_TOP, 7),
            step_row(ACT_QUERY, 2, 0, 7),
            // unknown action leaves the tree alone
            step_row(ACT_NONE, ID_TOP, ID_TOP, VAL_TOP),
            // own parent, re-add, and a re-add that closes a loop
            step_row(ACT_ADD, 2, 2, 9),
            step_row(ACT_QUERY, 2, 0, 9),
            step_row(ACT_ADD, 1, 0, 3),
            step_row(ACT_QUERY, ID_TOP, 0, 3),
            step_row(ACT_ADD, 1, 2, 5),
            step_row(ACT_QUERY, 2, ID_TOP, 6),
            // clear brings back the bare root
            step_row(ACT_CLEAR, ID_TOP, ID_TOP, VAL_TOP),
            step_row(ACT_QUERY, 0, 0, 1, 1'b1, 1'b1, 0),
            step_row(ACT_ADD, ID_TOP, 0, VAL_TOP),
            step_row(ACT_QUERY, ID_TOP, 0, VAL_TOP, 1'b1, 1'b1, ID_TOP)
        };

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < directed_rows.size(); i++)
            send_transaction(directed_rows[i].item, directed_rows[i].typed,
                             directed_rows[i].answer);

        // Mostly well-formed tree growth and searches, with some noise
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            calm           = (counted >= CALM_FIRST) && (counted < CALM_LAST);
            item.node_id   = ID_W'($urandom);
            item.parent_id = ID_W'($urandom);
            item.amount    = VAL_W'($urandom);
            roll           = $urandom_range(99);
            if (roll < 3)
                item.action = ACT_NONE;
            else if (roll < 5)
            begin
                item.action  = ACT_ADD;
                item.node_id = '0;
            end
            else
            begin
                counted++;
                if (roll < 6)
                    item.action = ACT_CLEAR;
                else if (roll < 48)
                begin
                    item.action = ACT_ADD;
                    pick = $urandom_range(19);
                    if (pick < 2 && tree_nodes.size() > 1)
                    begin
                        // re-add a live node, sometimes as its own parent
                        qnode = tree_nodes[$urandom_range(1, tree_nodes.size() - 1)];
                        item.node_id = ID_W'(qnode);
                        if (pick == 0)
                            item.parent_id = ID_W'(qnode);
                        else
                            item.parent_id =
                                ID_W'(tree_nodes[$urandom_range(tree_nodes.size() - 1)]);
                    end
                    else
                    begin
                        // grow deep chains by favoring the newest node as parent
                        item.node_id = ID_W'($urandom_range(1, ID_TOP));
                        if ($urandom_range(9) < 6)
                            item.parent_id = ID_W'(last_added);
                        else
                            item.parent_id =
                                ID_W'(tree_nodes[$urandom_range(tree_nodes.size() - 1)]);
                    end
                    case ($urandom_range(5))
                        0: item.amount = VAL_W'($urandom_range(4));
                        1: item.amount = '1;
                        default: ;
                    endcase
                end
                else
                begin
                    item.action = ACT_QUERY;
                    if ($urandom_range(1) == 1)
                        qnode = last_added;
                    else
                        qnode = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
                    item.node_id = ID_W'(qnode);
                    // aim thresholds near values on the node's own path
                    case ($urandom_range(9))
                        0: item.amount = '0;
                        1: item.amount = '1;
                        2, 3: ;
                        4: item.amount = value_of(qnode);
                        default:
                            item.amount = value_of(jump_at(qnode, $urandom_range(LIFT_LEVELS - 1)))
                                          + VAL_W'($urandom_range(2)) - VAL_W'(1);
                    endcase
                end
            end
            send_transaction(item, 1'b0, '0);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Drain outstanding answers, then watch for strays
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
